>>> sv/bbd_pkg.sv
`timescale 1ns / 1ps

package bbd_pkg;

	localparam int LINE_PIXELS = 2048;
	localparam int ADDR_W      = $clog2(LINE_PIXELS);
	localparam int FRAME_LINES = 4096;

	localparam int PIX_W    = 8;
	localparam int COL_W    = 11;
	localparam int ROW_W    = 12;
	localparam int WIDTH_W  = 12;
	localparam int HEIGHT_W = 13;
	localparam int CFG_W    = 13;
	localparam int IDX_W    = 2;

	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W     = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 3);

	localparam logic [IDX_W-1:0] REG_LAYOUT = 2'd0;
	localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [1:0] LAYOUT_RGGB = 2'd0;
	localparam logic [1:0] LAYOUT_BGGR = 2'd1;
	localparam logic [1:0] LAYOUT_GRBG = 2'd2;
	localparam logic [1:0] LAYOUT_GBRG = 2'd3;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} result_t;

	function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PIX_W:0] s;
		s = {1'b0, a} + {1'b0, b} + (PIX_W+1)'(1);
		return s[PIX_W:1];
	endfunction

	function automatic logic [PIX_W-1:0] avg4(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] c,
		input logic [PIX_W-1:0] d);
		logic [PIX_W+1:0] s;
		s = {2'b00, a} + {2'b00, b} + {2'b00, c} + {2'b00, d} + (PIX_W+2)'(2);
		return s[PIX_W+1:2];
	endfunction

endpackage

>>> sv/bbd_ram.sv
`timescale 1ns / 1ps

module bbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/bayer_bilinear_demosaic.sv
`timescale 1ns / 1ps
// channel   signals                             direction
// pixel in  in_valid, in_stall, raw_pixel       sink
// rgb out   out_valid, out_stall, red .. last   source
// config    cfg_write, cfg_index, cfg_data      sink, write only
//
// one pixel per cycle while in_stall is low; a pixel's result passes through the line
// store read, the window update and the result queue write before it leaves
// arst_n clears counters, window, queue and registers; line stores are not cleared
// in_stall rises only when the 4-entry result queue plus in-flight pixels fill

module bayer_bilinear_demosaic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [bbd_pkg::PIX_W-1:0]         raw_pixel,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [bbd_pkg::PIX_W-1:0]         red,
	output logic [bbd_pkg::PIX_W-1:0]         green,
	output logic [bbd_pkg::PIX_W-1:0]         blue,
	output logic [bbd_pkg::COL_W-1:0]         pixel_column,
	output logic [bbd_pkg::ROW_W-1:0]         pixel_row,
	output logic                              frame_last,
	input  logic                              cfg_write,
	input  logic [bbd_pkg::IDX_W-1:0]         cfg_index,
	input  logic [bbd_pkg::CFG_W-1:0]         cfg_data
);

	logic [1:0]                     layout_q;
	logic [bbd_pkg::WIDTH_W-1:0]    width_q;
	logic [bbd_pkg::HEIGHT_W-1:0]   height_q;
	logic [bbd_pkg::WIDTH_W-1:0]    eff_w;
	logic [bbd_pkg::HEIGHT_W-1:0]   eff_h;

	logic                           in_accept;
	logic [bbd_pkg::COL_W-1:0]      col_q;
	logic [bbd_pkg::ROW_W-1:0]      row_q;
	logic [bbd_pkg::WIDTH_W-1:0]    col_inc;
	logic [bbd_pkg::HEIGHT_W-1:0]   row_inc;
	logic                           emit;
	logic                           last;

	logic                           s1_valid;
	logic [bbd_pkg::PIX_W-1:0]      s1_pix;
	logic [bbd_pkg::ADDR_W-1:0]     s1_addr;
	logic                           s1_emit;
	logic                           s1_last;
	logic [bbd_pkg::COL_W-1:0]      s1_cx;
	logic [bbd_pkg::ROW_W-1:0]      s1_cy;

	logic                           s2_valid;
	logic                           s2_emit;
	logic                           s2_last;
	logic [bbd_pkg::COL_W-1:0]      s2_cx;
	logic [bbd_pkg::ROW_W-1:0]      s2_cy;

	logic [bbd_pkg::PIX_W-1:0]      up_rd;
	logic [bbd_pkg::PIX_W-1:0]      mid_rd;
	logic [bbd_pkg::PIX_W-1:0]      win_q [9];

	logic [bbd_pkg::PIX_W-1:0]      cross_avg, diag_avg, horiz_avg, vert_avg;
	logic                           ry, rx, py, px;
	bbd_pkg::result_t               res;

	bbd_pkg::result_t               fifo_q [bbd_pkg::FIFO_DEPTH];
	logic [bbd_pkg::FPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [bbd_pkg::FCNT_W-1:0]     count_q;
	logic [bbd_pkg::FCNT_W-1:0]     pending;
	logic                           push, pop;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= bbd_pkg::LAYOUT_RGGB;
			width_q  <= bbd_pkg::WIDTH_W'(640);
			height_q <= bbd_pkg::HEIGHT_W'(480);
		end else if (cfg_write) begin
			case (cfg_index)
				bbd_pkg::REG_LAYOUT: layout_q <= cfg_data[1:0];
				bbd_pkg::REG_WIDTH:  width_q  <= cfg_data[bbd_pkg::WIDTH_W-1:0];
				bbd_pkg::REG_HEIGHT: height_q <= cfg_data[bbd_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < bbd_pkg::WIDTH_W'(3)) begin
			eff_w = bbd_pkg::WIDTH_W'(3);
		end else if (width_q > bbd_pkg::WIDTH_W'(bbd_pkg::LINE_PIXELS)) begin
			eff_w = bbd_pkg::WIDTH_W'(bbd_pkg::LINE_PIXELS);
		end else begin
			eff_w = width_q;
		end
		if (height_q < bbd_pkg::HEIGHT_W'(3)) begin
			eff_h = bbd_pkg::HEIGHT_W'(3);
		end else if (height_q > bbd_pkg::HEIGHT_W'(bbd_pkg::FRAME_LINES)) begin
			eff_h = bbd_pkg::HEIGHT_W'(bbd_pkg::FRAME_LINES);
		end else begin
			eff_h = height_q;
		end
	end

	// stall counts every pixel in flight, emitting or not
	assign pending   = count_q + bbd_pkg::FCNT_W'(s1_valid) + bbd_pkg::FCNT_W'(s2_valid);
	assign in_stall  = pending >= bbd_pkg::FCNT_W'(bbd_pkg::FIFO_DEPTH);
	assign in_accept = in_valid && !in_stall;

	assign col_inc = {1'b0, col_q} + bbd_pkg::WIDTH_W'(1);
	assign row_inc = {1'b0, row_q} + bbd_pkg::HEIGHT_W'(1);
	assign emit    = (row_q >= bbd_pkg::ROW_W'(2)) && (col_q >= bbd_pkg::COL_W'(2))
		&& ({1'b0, row_q} < eff_h) && ({1'b0, col_q} < eff_w);
	assign last    = (row_inc == eff_h) && (col_inc == eff_w);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (row_inc >= eff_h) ? '0 : row_inc[bbd_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[bbd_pkg::COL_W-1:0];
			end
		end
	end

	// line stores: read at request, write back in the next cycle
	bbd_ram #(.WIDTH(bbd_pkg::PIX_W), .DEPTH(bbd_pkg::LINE_PIXELS)) u_upper (
		.clk   (clk),
		.we    (s1_valid),
		.waddr (s1_addr),
		.wdata (mid_rd),
		.re    (in_accept),
		.raddr (col_q[bbd_pkg::ADDR_W-1:0]),
		.rdata (up_rd)
	);

	bbd_ram #(.WIDTH(bbd_pkg::PIX_W), .DEPTH(bbd_pkg::LINE_PIXELS)) u_middle (
		.clk   (clk),
		.we    (s1_valid),
		.waddr (s1_addr),
		.wdata (s1_pix),
		.re    (in_accept),
		.raddr (col_q[bbd_pkg::ADDR_W-1:0]),
		.rdata (mid_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			s2_valid <= 1'b0;
		end else begin
			s1_valid <= in_accept;
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			s1_pix  <= raw_pixel;
			s1_addr <= col_q[bbd_pkg::ADDR_W-1:0];
			s1_emit <= emit;
			s1_last <= last;
			s1_cx   <= col_q - bbd_pkg::COL_W'(1);
			s1_cy   <= row_q - bbd_pkg::ROW_W'(1);
		end
		if (s1_valid) begin
			s2_emit <= s1_emit;
			s2_last <= s1_last;
			s2_cx   <= s1_cx;
			s2_cy   <= s1_cy;
		end
	end

	// 3x3 window, column 2 is the newest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_valid) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= up_rd;
			win_q[5] <= mid_rd;
			win_q[8] <= s1_pix;
		end
	end

	assign cross_avg = bbd_pkg::avg4(win_q[1], win_q[3], win_q[5], win_q[7]);
	assign diag_avg  = bbd_pkg::avg4(win_q[0], win_q[2], win_q[6], win_q[8]);
	assign horiz_avg = bbd_pkg::avg2(win_q[3], win_q[5]);
	assign vert_avg  = bbd_pkg::avg2(win_q[1], win_q[7]);

	// parity of the red site
	assign ry = (layout_q == bbd_pkg::LAYOUT_BGGR) || (layout_q == bbd_pkg::LAYOUT_GBRG);
	assign rx = (layout_q == bbd_pkg::LAYOUT_BGGR) || (layout_q == bbd_pkg::LAYOUT_GRBG);
	assign py = s2_cy[0];
	assign px = s2_cx[0];

	always_comb begin
		res.col  = s2_cx;
		res.row  = s2_cy;
		res.last = s2_last;
		if (py == ry && px == rx) begin
			res.red   = win_q[4];
			res.green = cross_avg;
			res.blue  = diag_avg;
		end else if (py != ry && px != rx) begin
			res.blue  = win_q[4];
			res.green = cross_avg;
			res.red   = diag_avg;
		end else if (py == ry) begin
			res.green = win_q[4];
			res.red   = horiz_avg;
			res.blue  = vert_avg;
		end else begin
			res.green = win_q[4];
			res.blue  = horiz_avg;
			res.red   = vert_avg;
		end
	end

	// result queue
	assign push = s2_valid && s2_emit;
	assign pop  = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + bbd_pkg::FPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + bbd_pkg::FPTR_W'(1);
			end
			count_q <= count_q + bbd_pkg::FCNT_W'(push) - bbd_pkg::FCNT_W'(pop);
		end
	end

	assign out_valid    = count_q != '0;
	assign red          = fifo_q[rd_ptr_q].red;
	assign green        = fifo_q[rd_ptr_q].green;
	assign blue         = fifo_q[rd_ptr_q].blue;
	assign pixel_column = fifo_q[rd_ptr_q].col;
	assign pixel_row    = fifo_q[rd_ptr_q].row;
	assign frame_last   = fifo_q[rd_ptr_q].last;

`ifndef NO_ASSERTIONS
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= bbd_pkg::FCNT_W'(bbd_pkg::FIFO_DEPTH))
		else $error("result queue overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < bbd_pkg::FCNT_W'(bbd_pkg::FIFO_DEPTH)) || pop)
		else $error("push into full result queue");

	a_addr_hazard: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && s1_valid) |-> (col_q[bbd_pkg::ADDR_W-1:0] != s1_addr))
		else $error("line store read and write back hit the same entry");

	a_s1_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> s1_valid)
		else $error("accepted pixel did not reach the line store stage");

	a_emit_coords: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (s2_cx != '0) && (s2_cy != '0))
		else $error("result emitted for a border pixel");
`endif

endmodule

>>> sim/bayer_bilinear_demosaic_tb.sv
`timescale 1ns / 1ps

module bayer_bilinear_demosaic_tb;
	import bbd_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_PIXELS = 675;

	class demosaic_scoreboard;
		logic [1:0] layout;
		logic [WIDTH_W-1:0] width;
		logic [HEIGHT_W-1:0] height;
		logic [PIX_W-1:0] upper_line [LINE_PIXELS];
		logic [PIX_W-1:0] middle_line [LINE_PIXELS];
		bit upper_set [LINE_PIXELS];
		bit middle_set [LINE_PIXELS];
		logic [PIX_W-1:0] win [9];
		int unsigned col_pos;
		int unsigned row_pos;
		result_t pending_rgb [$];
		int errors;

		function new();
			layout = LAYOUT_RGGB;
			width = WIDTH_W'(640);
			height = HEIGHT_W'(480);
			foreach (upper_line[i]) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
				upper_set[i] = 1'b0;
				middle_set[i] = 1'b0;
			end
			foreach (win[i])
				win[i] = '0;
			col_pos = 0;
			row_pos = 0;
			errors = 0;
		endfunction

		function int unsigned active_width();
			if (width < 3)
				return 3;
			if (width > LINE_PIXELS)
				return LINE_PIXELS;
			return width;
		endfunction

		function int unsigned active_height();
			if (height < 3)
				return 3;
			if (height > FRAME_LINES)
				return FRAME_LINES;
			return height;
		endfunction

		// leading columns that hold written data in both line stores
		function int unsigned filled_width();
			int unsigned n;
			n = 0;
			while (n < LINE_PIXELS && upper_set[n] && middle_set[n])
				n++;
			return n;
		endfunction

		function int unsigned mean2(int unsigned a, int unsigned b);
			return (a + b + 1) >> 1;
		endfunction

		function int unsigned mean4(int unsigned a, int unsigned b, int unsigned c,
			int unsigned d);
			return (a + b + c + d + 2) >> 2;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_LAYOUT: layout = data[1:0];
				REG_WIDTH:  width = data[WIDTH_W-1:0];
				REG_HEIGHT: height = data[HEIGHT_W-1:0];
				default: ;
			endcase
		endfunction

		// accepted pixel request: shift the window and predict the rgb of its center once the window lies inside the frame
		function void note_pixel(logic [PIX_W-1:0] pix);
			int unsigned w, h, addr, cx, cy, centre, cross_mean, diag, horiz, vert;
			bit ry, rx;
			result_t rgb;
			w = active_width();
			h = active_height();
			addr = col_pos % LINE_PIXELS;
			for (int k = 0; k < 3; k++) begin
				win[k*3] = win[k*3+1];
				win[k*3+1] = win[k*3+2];
			end
			win[2] = upper_line[addr];
			win[5] = middle_line[addr];
			win[8] = pix;
			upper_line[addr] = middle_line[addr];
			middle_line[addr] = pix;
			upper_set[addr] = middle_set[addr];
			middle_set[addr] = 1'b1;
			if (row_pos >= 2 && col_pos >= 2 && row_pos < h && col_pos < w) begin
				cx = col_pos - 1;
				cy = row_pos - 1;
				// parity of the red site
				ry = (layout == LAYOUT_BGGR || layout == LAYOUT_GBRG);
				rx = (layout == LAYOUT_BGGR || layout == LAYOUT_GRBG);
				centre = win[4];
				cross_mean = mean4(win[1], win[3], win[5], win[7]);
				diag = mean4(win[0], win[2], win[6], win[8]);
				horiz = mean2(win[3], win[5]);
				vert = mean2(win[1], win[7]);
				if (cy[0] == ry && cx[0] == rx) begin
					rgb.red = PIX_W'(centre);
					rgb.green = PIX_W'(cross_mean);
					rgb.blue = PIX_W'(diag);
				end else if (cy[0] != ry && cx[0] != rx) begin
					rgb.blue = PIX_W'(centre);
					rgb.green = PIX_W'(cross_mean);
					rgb.red = PIX_W'(diag);
				end else if (cy[0] == ry) begin
					rgb.green = PIX_W'(centre);
					rgb.red = PIX_W'(horiz);
					rgb.blue = PIX_W'(vert);
				end else begin
					rgb.green = PIX_W'(centre);
					rgb.blue = PIX_W'(horiz);
					rgb.red = PIX_W'(vert);
				end
				rgb.col = cx[COL_W-1:0];
				rgb.row = cy[ROW_W-1:0];
				rgb.last = (row_pos == h - 1 && col_pos == w - 1);
				pending_rgb.push_back(rgb);
			end
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h)
					row_pos = 0;
			end
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_rgb(result_t got);
			result_t want;
			if (pending_rgb.size() == 0) begin
				report_mismatch($sformatf("rgb at row %0d col %0d with nothing pending",
					got.row, got.col));
				return;
			end
			want = pending_rgb.pop_front();
			if (got !== want)
				report_mismatch($sformatf(
					"got r%0d c%0d %0d/%0d/%0d last %0d, want r%0d c%0d %0d/%0d/%0d last %0d",
					got.row, got.col, got.red, got.green, got.blue, got.last,
					want.row, want.col, want.red, want.green, want.blue, want.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] raw_pixel = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] red, green, blue;
	logic [COL_W-1:0] pixel_column;
	logic [ROW_W-1:0] pixel_row;
	logic frame_last;
	logic cfg_write = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	demosaic_scoreboard sb;
	int tx_idle = 33;
	int rx_idle = 83;
	int quiet_cycles = 0;

	always #10 clk = ~clk;

	bayer_bilinear_demosaic i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.raw_pixel    (raw_pixel),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.frame_last   (frame_last),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// rgb side: check what left at this edge, then pick the next stall
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_rgb('{red: red, green: green, blue: blue, col: pixel_column,
				row: pixel_row, last: frame_last});
		out_stall <= ($urandom_range(0, 99) < rx_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic set_profile(input int p);
		case (p)
			0: begin
				tx_idle = 33;
				rx_idle = 83;
			end
			1: begin
				tx_idle = 83;
				rx_idle = 33;
			end
			default: begin
				tx_idle = 0;
				rx_idle = 0;
			end
		endcase
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	// unused upper data bits carry noise
	task automatic write_settings(input logic [1:0] layout, input int wd, input int ht,
		input int mask);
		if (mask[0])
			put_reg(REG_LAYOUT, {11'($urandom), layout});
		if (mask[1])
			put_reg(REG_WIDTH, {1'($urandom), wd[WIDTH_W-1:0]});
		if (mask[2])
			put_reg(REG_HEIGHT, ht[HEIGHT_W-1:0]);
		cfg_write <= 1'b0;
	endtask

	task automatic send_pixels(input int count, input int fixed);
		logic [PIX_W-1:0] pix;
		for (int i = 0; i < count; i++) begin
			if (fixed >= 0)
				pix = fixed[PIX_W-1:0];
			else begin
				case ($urandom_range(0, 7))
					0: pix = '0;
					1: pix = '1;
					default: pix = PIX_W'($urandom);
				endcase
			end
			while ($urandom_range(0, 99) < tx_idle) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			raw_pixel <= pix;
			do
				@(posedge clk);
			while (in_stall);
			sb.note_pixel(pix);
		end
		in_valid <= 1'b0;
	endtask

	// block counters may still move after the last rgb, so keep waiting past it
	task automatic wait_drained();
		while (sb.pending_rgb.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int random_pixels, npix, wd, ht, mask, new_w;
		int unsigned w, h;
		logic [1:0] layout;
		sb = new();
		random_pixels = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturated window, then a clamped minimum frame of zeros
		set_profile(0);
		write_settings(LAYOUT_RGGB, 4, 4, 7);
		send_pixels(16, 255);
		wait_drained();
		write_settings(LAYOUT_GBRG, 2, 0, 7);
		send_pixels(9, 0);
		wait_drained();

		while (random_pixels < RANDOM_PIXELS) begin
			set_profile(random_pixels * 3 / RANDOM_PIXELS);
			layout = 2'($urandom_range(0, 3));
			case ($urandom_range(0, 9))
				0: wd = $urandom_range(0, 2);
				1: wd = $urandom_range(13, 48);
				2: wd = ($urandom_range(0, 3) == 0) ? $urandom_range(2049, 4095)
					: $urandom_range(3, 12);
				default: wd = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0: ht = $urandom_range(0, 2);
				1: ht = ($urandom_range(0, 3) == 0) ? $urandom_range(4097, 8191)
					: $urandom_range(8, 12);
				default: ht = $urandom_range(3, 7);
			endcase
			mask = $urandom_range(0, 1) ? 7 : $urandom_range(1, 7);

			// a line that grows mid-frame stays within columns both line stores hold
			if (mask[1] && (sb.col_pos != 0 || sb.row_pos != 0)) begin
				new_w = (wd < 3) ? 3 : ((wd > LINE_PIXELS) ? LINE_PIXELS : wd);
				if (new_w > sb.active_width() && new_w > sb.filled_width())
					wd = sb.active_width();
			end
			write_settings(layout, wd, ht, mask);

			// mostly run to the end of the frame, sometimes stop mid-frame
			w = sb.active_width();
			h = sb.active_height();
			npix = 0;
			if (sb.col_pos < w && sb.row_pos < h && $urandom_range(0, 3) != 0)
				npix = (h - 1 - sb.row_pos) * w + (w - sb.col_pos);
			if (npix == 0 || npix > 400)
				npix = $urandom_range(1, 60);
			send_pixels(npix, -1);
			random_pixels += npix;
			wait_drained();
		end

		if (sb.pending_rgb.size() != 0)
			sb.report_mismatch($sformatf("%0d rgb results never came", sb.pending_rgb.size()));
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
sv/bbd_pkg.sv
sv/bbd_ram.sv
sv/bayer_bilinear_demosaic.sv
sim/bayer_bilinear_demosaic_tb.sv
